// File: sv/ftsr_pkg.sv
package ftsr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ACC_BITS  = 32;
   localparam int STEP_BITS = 28;
   localparam int XW        = 10;
   localparam int YW        = 6;

   typedef struct packed {
      logic [XW-1:0] top_x;
      logic [YW-1:0] top_y;
      logic [XW-1:0] mid_x;
      logic [YW-1:0] mid_y;
      logic [XW-1:0] bot_x;
      logic [YW-1:0] bot_y;
   } tri_type;

endpackage

// File: sv/filled_triangle_span_rasterizer.sv
// filled triangle span rasterizer
// req channel: one triangle per transaction, three vertices in req_tdata
// rsp channel: one span per row from top row to one above bottom row,
//   rsp_tlast marks the final span; flat triangles give no transactions
// a front stage clamps and sorts vertices, drops flat triangles and puts the rest
//   into a two-entry queue; the back stage runs the edge setup and walks the rows
// setup per edge is a restoring divider (long edge, then upper short edge if
//   present, else lower short edge); with an upper short edge, the lower short
//   edge is set up when the walk reaches the middle row
// walking issues one span per cycle while rsp_tready is high, except while the
//   lower short edge is being set up
// when rsp_tready is low the walk holds; the queue keeps taking triangles
//   until both entries are full
// reset clears the FSM state, the output valid and the queue count and pointers; no clearing pass
module filled_triangle_span_rasterizer #(
   parameter int TILE_ROWS = 64,
   parameter int X_BITS    = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // long_edge_x, short_edge_x, span_row, zero pad
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic              q_valid, q_ready;
   ftsr_pkg::tri_type q_data;
   logic [26:0]       bdata;

   ftsr_front #(.TILE_ROWS(TILE_ROWS), .X_BITS(X_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .q_valid, .q_ready, .q_data
   );

   ftsr_back #(.X_BITS(X_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(bdata)
   );

   assign rsp_tdata = {6'd0, bdata[25:0]};
   assign rsp_tlast = bdata[26];

endmodule

// File: sv/ftsr_front.sv
module ftsr_front #(
   parameter int TILE_ROWS = 64,
   parameter int X_BITS    = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [47:0]       in_data,
   output logic              q_valid,
   input  logic              q_ready,
   output ftsr_pkg::tri_type q_data
);

   localparam int XW = ftsr_pkg::XW;
   localparam int YW = ftsr_pkg::YW;
   localparam logic [YW-1:0] YMAX = YW'(TILE_ROWS - 1);
   localparam logic [XW-1:0] XMASK = XW'((1 << X_BITS) - 1);

   logic [XW-1:0] x1, x2, x3, sx1, sx2, sx3;
   logic [YW-1:0] y1, y2, y3, sy1, sy2, sy3;
   ftsr_pkg::tri_type slot_ff [2];
   ftsr_pkg::tri_type tri_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;

   always_comb begin
      x1 = in_data[9:0] & XMASK;
      y1 = in_data[15:10];
      x2 = in_data[25:16] & XMASK;
      y2 = in_data[31:26];
      x3 = in_data[41:32] & XMASK;
      y3 = in_data[47:42];
      if (y1 > YMAX) y1 = YMAX;
      if (y2 > YMAX) y2 = YMAX;
      if (y3 > YMAX) y3 = YMAX;
      sx1 = x1; sx2 = x2; sx3 = x3;
      sy1 = y1; sy2 = y2; sy3 = y3;
      if (y1 > y3) begin
         if (y2 < y3) begin
            sx1 = x2; sx2 = x3; sx3 = x1;
            sy1 = y2; sy2 = y3; sy3 = y1;
         end else if (y2 > y1) begin
            sx1 = x3; sx3 = x2; sx2 = x1;
            sy1 = y3; sy3 = y2; sy2 = y1;
         end else begin
            sx1 = x3; sx3 = x1;
            sy1 = y3; sy3 = y1;
         end
      end else begin
         if (y2 < y1) begin
            sx1 = x2; sx2 = x1;
            sy1 = y2; sy2 = y1;
         end else if (y2 > y3) begin
            sx2 = x3; sx3 = x2;
            sy2 = y3; sy3 = y2;
         end
      end
      tri_in = '{sx1, sy1, sx2, sy2, sx3, sy3};
   end

   // flat triangles are dropped here
   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && (sy1 < sy3);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = slot_ff[rp_ff];
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) slot_ff[wp_ff] <= tri_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (q_data.top_y <= q_data.mid_y && q_data.mid_y <= q_data.bot_y
                   && q_data.top_y < q_data.bot_y)) else $error("unsorted triangle");

endmodule

// File: sv/ftsr_back.sv
module ftsr_back #(
   parameter int X_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  ftsr_pkg::tri_type q_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [26:0]       out_data
);

   localparam int XW = ftsr_pkg::XW;
   localparam int YW = ftsr_pkg::YW;
   localparam int AW = ftsr_pkg::ACC_BITS;
   localparam int SW = ftsr_pkg::STEP_BITS;
   localparam int DW = 27;            // dividend magnitude bits
   localparam int CW = 5;
   localparam logic [XW-1:0] XHI = XW'((1 << X_BITS) - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_INIT = 5'b00100,
      S_SPAN = 5'b01000,
      S_WAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   ftsr_pkg::tri_type tri_ff;
   logic [DW-1:0] quo_ff, rem_ff;
   logic [YW-1:0] den_ff;
   logic          neg_ff;
   logic [CW-1:0] dcnt_ff;
   logic [1:0]    dsel_ff;       // 0 long, 1 upper short, 2 lower short
   logic signed [AW-1:0] lacc_ff, sacc_ff;
   logic signed [SW-1:0] lstep_ff, sstep_ff;
   logic [YW-1:0] row_ff;
   logic          lower_ff;
   logic          ov_ff;
   logic [26:0]   od_ff;

   // divider operands for the selected edge
   logic [XW-1:0] xa, xb;
   logic [YW-1:0] ya, yb;
   logic signed [XW:0] dx;
   logic [XW-1:0] adx;
   always_comb begin
      case (dsel_ff)
         2'd0: begin xa = tri_ff.top_x; ya = tri_ff.top_y;
                     xb = tri_ff.bot_x; yb = tri_ff.bot_y; end
         2'd1: begin xa = tri_ff.top_x; ya = tri_ff.top_y;
                     xb = tri_ff.mid_x; yb = tri_ff.mid_y; end
         default: begin xa = tri_ff.mid_x; ya = tri_ff.mid_y;
                     xb = tri_ff.bot_x; yb = tri_ff.bot_y; end
      endcase
      dx  = $signed({1'b0, xb}) - $signed({1'b0, xa});
      adx = dx[XW] ? XW'(-dx) : dx[XW-1:0];
   end

   logic [YW:0]   trial;
   logic [YW-1:0] rsh;
   logic          qbit;
   always_comb begin
      trial = {rem_ff[YW-1:0], quo_ff[DW-1]} - {1'b0, den_ff};
      qbit  = !trial[YW];
      rsh   = qbit ? trial[YW-1:0] : {rem_ff[YW-2:0], quo_ff[DW-1]};
   end

   logic signed [SW-1:0] step_res;
   logic signed [AW-1:0] start_res;
   always_comb begin
      step_res  = neg_ff ? -$signed(SW'(quo_ff)) : $signed(SW'(quo_ff));
      start_res = $signed(AW'({xa, 16'd0})) + AW'(32'sd32768)
                + AW'(step_res >>> 1);
   end

   function automatic logic [XW-1:0] clampx(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] v;
      v = a >>> ftsr_pkg::FRAC_BITS;
      if (v < 0) return '0;
      if (v > $signed(AW'(XHI))) return XHI;
      return v[XW-1:0];
   endfunction

   logic last_row, out_free, emit;
   assign last_row  = (row_ff + 6'd1 == tri_ff.bot_y);
   assign out_free  = !ov_ff || out_ready;
   assign q_ready   = (state_ff == S_IDLE);
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign emit      = (state_ff == S_SPAN) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (q_valid) state_in = S_DIV;
         S_DIV:  if (dcnt_ff == '0) state_in = S_INIT;
         S_INIT: state_in = (dsel_ff == 2'd0) ? S_DIV : S_SPAN;
         S_SPAN: if (emit) begin
            if (last_row) state_in = S_WAIT;
            else if (!lower_ff && row_ff + 6'd1 == tri_ff.mid_y) state_in = S_DIV;
         end
         S_WAIT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         lower_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_free) ov_ff <= emit;
         case (state_ff)
            S_IDLE: lower_ff <= 1'b0;
            S_SPAN: if (emit && !last_row && row_ff + 6'd1 == tri_ff.mid_y)
               lower_ff <= 1'b1;
            default: ;
         endcase
      end
      if (emit) od_ff <= {last_row, row_ff, clampx(sacc_ff), clampx(lacc_ff)};
      case (state_ff)
         S_IDLE: begin
            tri_ff  <= q_data;
            dsel_ff <= 2'd0;
            row_ff  <= q_data.top_y;
         end
         S_INIT: begin
            if (dsel_ff == 2'd0) begin
               lstep_ff <= step_res; lacc_ff <= start_res;
            end else begin
               sstep_ff <= step_res; sacc_ff <= start_res;
            end
         end
         default: ;
      endcase
      // setup sequence: load dividend, run DW steps, commit; repeat per edge
      if (state_in == S_DIV && state_ff != S_DIV) begin
         dcnt_ff <= CW'(DW);
         rem_ff  <= '0;
         if (state_ff == S_SPAN) dsel_ff <= 2'd2;
      end else if (state_ff == S_DIV) begin
         if (dcnt_ff == CW'(DW)) begin
            den_ff <= yb - ya;
            neg_ff <= dx[XW];
            quo_ff <= DW'({adx, 16'd0});
            dcnt_ff <= dcnt_ff - 1'b1;
         end else begin
            quo_ff  <= {quo_ff[DW-2:0], qbit};
            rem_ff  <= DW'(rsh);
            if (dcnt_ff != '0) dcnt_ff <= dcnt_ff - 1'b1;
         end
      end
      // flat top goes straight to the lower short edge
      if (state_ff == S_INIT && dsel_ff == 2'd0) begin
         dsel_ff <= (tri_ff.top_y < tri_ff.mid_y) ? 2'd1 : 2'd2;
      end
      if (emit) begin
         row_ff  <= row_ff + 6'd1;
         lacc_ff <= lacc_ff + AW'(lstep_ff);
         sacc_ff <= sacc_ff + AW'(sstep_ff);
      end
   end

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit |-> !q_ready) else $error("span while idle");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && last_row) |=> state_ff == S_WAIT) else $error("missed end of triangle");
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPAN |-> row_ff < tri_ff.bot_y) else $error("row past bottom");

endmodule

// File: tb/tb_filled_triangle_span_rasterizer.sv
module tb_filled_triangle_span_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TILE_ROWS = 64;
   localparam int X_BITS    = 10;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [9:0] long_x;
      logic [9:0] short_x;
      logic [5:0] row;
      logic       last;
   } span_t;

   class span_scoreboard;
      span_t spans_due[$];
      int    fail_count;
      int    spans_seen;
      int    triangles_seen;

      function longint floor_sh(longint v);
         return v >>> 16;
      endfunction

      function longint floor_half(longint v);
         return v >>> 1;
      endfunction

      function logic [9:0] clamp_x(longint acc);
         longint v;
         v = floor_sh(acc);
         if (v < 0) v = 0;
         if (v > (1 << X_BITS) - 1) v = (1 << X_BITS) - 1;
         return v[9:0];
      endfunction

      function longint step_of(longint xa, longint ya, longint xb, longint yb);
         longint dy;
         dy = yb - ya;
         if (dy <= 0) return 0;
         return ((xb - xa) * 65536) / dy;
      endfunction

      function void note_triangle(logic [47:0] d);
         longint x1, y1, x2, y2, x3, y3, t, y, ls, la, ss, sa;
         span_t s;
         x1 = longint'(d[9:0]);   y1 = longint'(d[15:10]);
         x2 = longint'(d[25:16]); y2 = longint'(d[31:26]);
         x3 = longint'(d[41:32]); y3 = longint'(d[47:42]);
         if (y1 > TILE_ROWS - 1) y1 = TILE_ROWS - 1;
         if (y2 > TILE_ROWS - 1) y2 = TILE_ROWS - 1;
         if (y3 > TILE_ROWS - 1) y3 = TILE_ROWS - 1;
         triangles_seen++;
         if (y1 > y3) begin
            if (y2 < y3) begin
               t = x1; x1 = x2; x2 = x3; x3 = t;
               t = y1; y1 = y2; y2 = y3; y3 = t;
            end else if (y2 > y1) begin
               t = x1; x1 = x3; x3 = x2; x2 = t;
               t = y1; y1 = y3; y3 = y2; y2 = t;
            end else begin
               t = x1; x1 = x3; x3 = t;
               t = y1; y1 = y3; y3 = t;
            end
         end else begin
            if (y2 < y1) begin
               t = x1; x1 = x2; x2 = t;
               t = y1; y1 = y2; y2 = t;
            end else if (y2 > y3) begin
               t = x2; x2 = x3; x3 = t;
               t = y2; y2 = y3; y3 = t;
            end
         end
         if (!(y1 < y3)) return;
         ls = step_of(x1, y1, x3, y3);
         la = x1 * 65536 + 32768 + floor_half(ls);
         ss = 0; sa = 0;
         if (y1 < y2) begin
            ss = step_of(x1, y1, x2, y2);
            sa = x1 * 65536 + 32768 + floor_half(ss);
         end
         for (y = y1; y < y3; y++) begin
            if (y == y2) begin
               ss = step_of(x2, y2, x3, y3);
               sa = x2 * 65536 + 32768 + floor_half(ss);
            end
            s.long_x  = clamp_x(la);
            s.short_x = clamp_x(sa);
            s.row     = y[5:0];
            s.last    = (y + 1 == y3);
            spans_due.push_back(s);
            la += ls;
            sa += ss;
         end
      endfunction

      function void check_span(logic [31:0] d, logic last);
         span_t e;
         spans_seen++;
         if (spans_due.size() == 0) begin
            $error("unexpected span transaction data=%h", d);
            fail_count++;
            return;
         end
         e = spans_due.pop_front();
         if (d[9:0] !== e.long_x) begin
            $error("long_edge_x expected %0d actual %0d", e.long_x, d[9:0]);
            fail_count++;
         end
         if (d[19:10] !== e.short_x) begin
            $error("short_edge_x expected %0d actual %0d", e.short_x, d[19:10]);
            fail_count++;
         end
         if (d[25:20] !== e.row) begin
            $error("span_row expected %0d actual %0d", e.row, d[25:20]);
            fail_count++;
         end
         if (last !== e.last) begin
            $error("last_span expected %0d actual %0d", e.last, last);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   longint cycle_count = 0;
   span_scoreboard board = new();

   filled_triangle_span_rasterizer #(.TILE_ROWS(TILE_ROWS), .X_BITS(X_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_filled_triangle_span_rasterizer failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_span(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_triangle(logic [9:0] ax, logic [5:0] ay, logic [9:0] bx,
                                logic [5:0] by, logic [9:0] cx, logic [5:0] cy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {cy, cx, by, bx, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_triangle({cy, cx, by, bx, ay, ax});
   endtask

   task automatic send_random(int n);
      logic [9:0] ax, bx, cx;
      logic [5:0] ay, by, cy;
      for (int i = 0; i < n; i++) begin
         ax = 10'($urandom); bx = 10'($urandom); cx = 10'($urandom);
         if ($urandom_range(3) == 0) begin
            ay = 6'($urandom); by = 6'($urandom); cy = 6'($urandom);
         end else begin
            ay = 6'($urandom_range(15)); by = 6'(ay + $urandom_range(12));
            cy = 6'(ay + $urandom_range(12));
         end
         if ($urandom_range(9) == 0) by = ay;
         if ($urandom_range(5) == 0) begin
            ax = $urandom_range(1) ? 10'h3ff : 10'h000;
         end
         send_triangle(ax, ay, bx, by, cx, cy);
      end
   endtask

   task automatic drain_spans();
      req_tvalid <= 0;
      while (board.spans_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 21;
      recv_idle_pct = 55;
      send_triangle(10'd0, 6'd0, 10'd1023, 6'd63, 10'd0, 6'd63);
      send_triangle(10'd1023, 6'd63, 10'd0, 6'd0, 10'd1023, 6'd0);
      send_triangle(10'd5, 6'd10, 10'd100, 6'd10, 10'd7, 6'd10);
      send_triangle(10'd100, 6'd20, 10'd50, 6'd10, 10'd0, 6'd30);
      send_triangle(10'd500, 6'd30, 10'd600, 6'd5, 10'd400, 6'd5);
      send_triangle(10'd500, 6'd5, 10'd600, 6'd30, 10'd400, 6'd30);
      send_triangle(10'd0, 6'd0, 10'd1023, 6'd1, 10'd0, 6'd2);
      send_triangle(10'd1023, 6'd0, 10'd0, 6'd62, 10'd1023, 6'd63);
      send_triangle(10'h2aa, 6'h2a, 10'h155, 6'h15, 10'h3ff, 6'h3f);
      send_triangle(10'd300, 6'd40, 10'd200, 6'd41, 10'd100, 6'd39);
      send_triangle(10'd1, 6'd1, 10'd2, 6'd3, 10'd3, 6'd2);
      send_triangle(10'd1, 6'd3, 10'd2, 6'd2, 10'd3, 6'd1);
      send_triangle(10'd1, 6'd2, 10'd2, 6'd1, 10'd3, 6'd3);
      drain_spans();
      send_random(90);
      drain_spans();
      send_idle_pct = 55;
      recv_idle_pct = 21;
      send_random(90);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(90);
      drain_spans();
      repeat (200) @(posedge clock);
      $display("covered %0d triangles and %0d spans under varied backpressure",
               board.triangles_seen, board.spans_seen);
      if (board.fail_count == 0 && board.spans_due.size() == 0) begin
         $display("tb_filled_triangle_span_rasterizer passed");
      end else begin
         $display("tb_filled_triangle_span_rasterizer failed");
      end
      $finish;
   end
endmodule

// File: filled_triangle_span_rasterizer.f
sv/ftsr_pkg.sv
sv/ftsr_front.sv
sv/ftsr_back.sv
sv/filled_triangle_span_rasterizer.sv
tb/tb_filled_triangle_span_rasterizer.sv
